// File: src/cartesian_to_spherical_defines.svh
// Assertion macros shared by the cartesian to spherical block.
`ifndef CARTESIAN_TO_SPHERICAL_DEFINES_SVH
`define CARTESIAN_TO_SPHERICAL_DEFINES_SVH

// Condition holds at every edge outside reset.
`define C2S_ASSERT_HOLDS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Trigger implies condition in the same cycle.
`define C2S_ASSERT_IMPLIES(lbl, trig, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |-> (cond)) else $error(msg);

// Trigger implies condition in the next cycle.
`define C2S_ASSERT_NEXT(lbl, trig, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cond)) else $error(msg);

`endif

// File: src/c2s_pkg.sv
// Shared widths, constants and the arctangent table of the spherical converter.
package c2s_pkg;

  localparam int COORD_W  = 32;          // Q15.16 coordinate
  localparam int ROOT_W   = 32;          // Q16.16 root
  localparam int SQ_W     = 2 * ROOT_W;  // Q32.32 sum of squares
  localparam int REM_W    = SQ_W + 2;    // root remainder, room for the trial term
  localparam int SQRT_LAT = ROOT_W + 2;  // load, one bit per stage, rounding
  localparam int DP_W     = 36;          // CORDIC vector width, covers gain growth
  localparam int ACC_W    = 36;          // Q5.30 angle accumulator plus sign
  localparam int ACC_FRAC = 30;
  localparam int ATAN_W   = 30;
  localparam int POLAR_W  = 30;
  localparam int AZIM_W   = 31;

  localparam logic signed [ACC_W-1:0] PI_Q30 = 36'sd3373259426;

  // atan(2^-i) in Q0.30
  function automatic logic [ATAN_W-1:0] atan_q30(input logic [4:0] idx);
    logic [ATAN_W-1:0] v;
    case (idx)
      5'd0:    v = 30'h3243F6A8;
      5'd1:    v = 30'h1DAC6705;
      5'd2:    v = 30'h0FADBAFC;
      5'd3:    v = 30'h07F56EA6;
      5'd4:    v = 30'h03FEAB76;
      5'd5:    v = 30'h01FFD55B;
      5'd6:    v = 30'h00FFFAAA;
      5'd7:    v = 30'h007FFF55;
      5'd8:    v = 30'h003FFFEA;
      5'd9:    v = 30'h001FFFFD;
      5'd10:   v = 30'h000FFFFF;
      5'd11:   v = 30'h0007FFFF;
      5'd12:   v = 30'h0003FFFF;
      5'd13:   v = 30'h0001FFFF;
      5'd14:   v = 30'h0000FFFF;
      5'd15:   v = 30'h00007FFF;
      5'd16:   v = 30'h00003FFF;
      5'd17:   v = 30'h00001FFF;
      5'd18:   v = 30'h00000FFF;
      5'd19:   v = 30'h000007FF;
      5'd20:   v = 30'h000003FF;
      5'd21:   v = 30'h000001FF;
      5'd22:   v = 30'h000000FF;
      5'd23:   v = 30'h0000007F;
      5'd24:   v = 30'h0000003F;
      5'd25:   v = 30'h0000001F;
      5'd26:   v = 30'h0000000F;
      5'd27:   v = 30'h00000008;
      5'd28:   v = 30'h00000004;
      5'd29:   v = 30'h00000002;
      5'd30:   v = 30'h00000001;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

// File: src/c2s_isqrt.sv
// Pipelined integer square root, one root bit per stage, rounded to nearest.
module c2s_isqrt
  import c2s_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic [SQ_W-1:0]   in_sq,
  output logic              out_valid,
  output logic [ROOT_W-1:0] out_root
);

  logic [ROOT_W:0]    v_r;
  logic [ROOT_W-1:0]  q_r   [ROOT_W+1];
  logic [REM_W-1:0]   rem_r [ROOT_W+1];
  logic               vo_r;
  logic [ROOT_W-1:0]  root_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r  <= '0;
      vo_r <= 1'b0;
    end else begin
      v_r  <= {v_r[ROOT_W-1:0], in_valid};
      vo_r <= v_r[ROOT_W];
    end
  end

  always_ff @(posedge clk) begin
    q_r[0]   <= '0;
    rem_r[0] <= REM_W'(in_sq);
  end

  // stage k decides root bit ROOT_W-k; rem holds n - q*q
  for (genvar k = 1; k <= ROOT_W; k++) begin : g_step
    localparam int B = ROOT_W - k;
    logic [REM_W-1:0] delta;
    logic             take;
    assign delta = (REM_W'(q_r[k-1]) << (B + 1)) + (REM_W'(1) << (2 * B));
    assign take  = rem_r[k-1] >= delta;
    always_ff @(posedge clk) begin
      q_r[k]   <= take ? (q_r[k-1] | (ROOT_W'(1) << B)) : q_r[k-1];
      rem_r[k] <= take ? (rem_r[k-1] - delta) : rem_r[k-1];
    end
  end

  always_ff @(posedge clk) begin
    root_r <= q_r[ROOT_W] + ROOT_W'(rem_r[ROOT_W] > REM_W'(q_r[ROOT_W]));
  end

  assign out_valid = vo_r;
  assign out_root  = root_r;

endmodule

// File: src/c2s_cordic.sv
// Pipelined vectoring CORDIC giving atan2(b, a), rounded and clamped to +-pi.
module c2s_cordic
  import c2s_pkg::*;
#(
  parameter int STEPS = 24,
  parameter int AFB   = 28
)
(
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  input  logic signed [DP_W-1:0]  in_b,
  input  logic signed [DP_W-1:0]  in_a,
  output logic                    out_valid,
  output logic signed [ACC_W-1:0] out_angle
);

  localparam int SH = ACC_FRAC - AFB;
  localparam logic signed [ACC_W-1:0] HALF_C = signed'(ACC_W'(1) << (SH - 1));
  localparam logic signed [ACC_W-1:0] PI_OUT = (PI_Q30 + HALF_C) >>> SH;

  logic [STEPS:0]          v_r;
  logic                    vo_r;
  logic signed [DP_W-1:0]  a_r   [STEPS+1];
  logic signed [DP_W-1:0]  b_r   [STEPS+1];
  logic signed [ACC_W-1:0] acc_r [STEPS+1];
  logic signed [ACC_W-1:0] rnd;
  logic signed [ACC_W-1:0] ang_nxt;
  logic signed [ACC_W-1:0] ang_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r  <= '0;
      vo_r <= 1'b0;
    end else begin
      v_r  <= {v_r[STEPS-1:0], in_valid};
      vo_r <= v_r[STEPS];
    end
  end

  // left half plane: flip the vector, start from +-pi
  always_ff @(posedge clk) begin
    if (in_a[DP_W-1]) begin
      a_r[0]   <= -in_a;
      b_r[0]   <= -in_b;
      acc_r[0] <= in_b[DP_W-1] ? -PI_Q30 : PI_Q30;
    end else begin
      a_r[0]   <= in_a;
      b_r[0]   <= in_b;
      acc_r[0] <= '0;
    end
  end

  for (genvar k = 1; k <= STEPS; k++) begin : g_rot
    localparam int I = k - 1;
    logic signed [DP_W-1:0]  da;
    logic signed [DP_W-1:0]  db;
    logic signed [ACC_W-1:0] ang;
    logic                    neg;
    assign da  = b_r[k-1] >>> I;
    assign db  = a_r[k-1] >>> I;
    assign ang = signed'(ACC_W'(atan_q30(5'(I))));
    assign neg = b_r[k-1][DP_W-1];
    always_ff @(posedge clk) begin
      if (neg) begin
        a_r[k]   <= a_r[k-1] - da;
        b_r[k]   <= b_r[k-1] + db;
        acc_r[k] <= acc_r[k-1] - ang;
      end else begin
        a_r[k]   <= a_r[k-1] + da;
        b_r[k]   <= b_r[k-1] - db;
        acc_r[k] <= acc_r[k-1] + ang;
      end
    end
  end

  always_comb begin
    rnd = (acc_r[STEPS] + HALF_C) >>> SH;
    if (rnd > PI_OUT) begin
      ang_nxt = PI_OUT;
    end else if (rnd < -PI_OUT) begin
      ang_nxt = -PI_OUT;
    end else begin
      ang_nxt = rnd;
    end
  end

  always_ff @(posedge clk) begin
    ang_r <= ang_nxt;
  end

  assign out_valid = vo_r;
  assign out_angle = ang_r;

endmodule

// File: src/cartesian_to_spherical.sv
// Top level of the cartesian to spherical converter.
//
// Usage: drive in_x_coord, in_y_coord and in_z_coord (signed Q15.16) and
// raise start; the request is taken at a rising edge where start is high and
// busy is low. busy is high only in and just after reset, so once out of reset
// a new request may be issued on every clock cycle.
// Each result shows for exactly one cycle with out_valid high: out_radius
// (Q16.16), out_polar_angle and out_azimuth (radians, Q2.ANGLE_FRAC_BITS) and
// out_axis_error, set when x and y are both zero; the angles then read zero
// while the radius is still correct.
// Throughput: one request per cycle. The pipeline is four front stages
// (capture, abs, squares, sum), 34 stages of the square roots at one root
// bit per stage, CORDIC_STEPS + 2 CORDIC stages and the output register.
// Reset (rst_n low, synchronous) empties the pipeline: every valid bit clears
// and no result comes out for requests in flight. The receiver cannot stall,
// so the pipeline never holds and results leave in request order.
`include "cartesian_to_spherical_defines.svh"

module cartesian_to_spherical
  import c2s_pkg::*;
#(
  parameter int CORDIC_STEPS    = 24,
  parameter int ANGLE_FRAC_BITS = 28
)
(
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  output logic                      busy,
  input  logic signed [COORD_W-1:0] in_x_coord,
  input  logic signed [COORD_W-1:0] in_y_coord,
  input  logic signed [COORD_W-1:0] in_z_coord,
  output logic                      out_valid,
  output logic [ROOT_W-1:0]         out_radius,
  output logic [POLAR_W-1:0]        out_polar_angle,
  output logic signed [AZIM_W-1:0]  out_azimuth,
  output logic                      out_axis_error
);

  localparam int CORDIC_LAT = CORDIC_STEPS + 2;
  // side data rides from stage 2 to the square root outputs
  localparam int SIDE_D     = SQRT_LAT + 3;

  typedef struct packed {
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic signed [COORD_W-1:0] z;
    logic                      axis;
  } side_t;

  typedef struct packed {
    logic [ROOT_W-1:0] radius;
    logic              axis;
  } rad_t;

  logic busy_r;
  logic accept;

  // front end
  logic                      v1_r, v2_r, v3_r, v4_r;
  logic signed [COORD_W-1:0] x1_r, y1_r, z1_r;
  logic [COORD_W-1:0]        ax2_r, ay2_r, az2_r;
  logic [SQ_W-1:0]           sqx3_r, sqy3_r, sqz3_r;
  logic [SQ_W-1:0]           sxy4_r, sqz4_r;

  side_t side_r [SIDE_D];
  rad_t  rad_r  [CORDIC_LAT];
  side_t side_q;

  logic              sq_rad_vld, sq_rho_vld;
  logic [ROOT_W-1:0] sq_rad, sq_rho;

  logic                    cd_pol_vld, cd_azi_vld;
  logic signed [ACC_W-1:0] cd_pol, cd_azi;

  logic                      out_valid_r;
  logic [ROOT_W-1:0]         radius_r;
  logic [POLAR_W-1:0]        polar_r, polar_nxt;
  logic signed [AZIM_W-1:0]  azim_r, azim_nxt;
  logic                      axis_r;

  // busy only covers reset and the cycle after it
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b1;
    end else begin
      busy_r <= 1'b0;
    end
  end

  assign busy   = busy_r;
  assign accept = start && !busy_r;

  // valid bits of the front stages
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      v1_r <= accept;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
    end
  end

  // stage 1 capture, stage 2 magnitudes, stage 3 squares, stage 4 x^2+y^2
  always_ff @(posedge clk) begin
    x1_r   <= in_x_coord;
    y1_r   <= in_y_coord;
    z1_r   <= in_z_coord;
    ax2_r  <= x1_r[COORD_W-1] ? (~x1_r + 1'b1) : x1_r;
    ay2_r  <= y1_r[COORD_W-1] ? (~y1_r + 1'b1) : y1_r;
    az2_r  <= z1_r[COORD_W-1] ? (~z1_r + 1'b1) : z1_r;
    sqx3_r <= SQ_W'(ax2_r) * SQ_W'(ax2_r);
    sqy3_r <= SQ_W'(ay2_r) * SQ_W'(ay2_r);
    sqz3_r <= SQ_W'(az2_r) * SQ_W'(az2_r);
    sxy4_r <= sqx3_r + sqy3_r;
    sqz4_r <= sqz3_r;
  end

  // coordinates and the axis flag wait for the square roots
  always_ff @(posedge clk) begin
    side_r[0].x    <= x1_r;
    side_r[0].y    <= y1_r;
    side_r[0].z    <= z1_r;
    side_r[0].axis <= (x1_r == '0) && (y1_r == '0);
    for (int k = 1; k < SIDE_D; k++) begin
      side_r[k] <= side_r[k-1];
    end
  end

  assign side_q = side_r[SIDE_D-1];

  // radius from x^2+y^2+z^2, rho from x^2+y^2; the sum never exceeds 64 bits
  c2s_isqrt u_sqrt_rad (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (v4_r),
    .in_sq     (sxy4_r + sqz4_r),
    .out_valid (sq_rad_vld),
    .out_root  (sq_rad)
  );

  c2s_isqrt u_sqrt_rho (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (v4_r),
    .in_sq     (sxy4_r),
    .out_valid (sq_rho_vld),
    .out_root  (sq_rho)
  );

  // polar angle: atan2(rho, z)
  c2s_cordic #(
    .STEPS (CORDIC_STEPS),
    .AFB   (ANGLE_FRAC_BITS)
  ) u_cordic_pol (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (sq_rho_vld),
    .in_b      (signed'(DP_W'(sq_rho))),
    .in_a      (DP_W'($signed(side_q.z))),
    .out_valid (cd_pol_vld),
    .out_angle (cd_pol)
  );

  // azimuth: atan2(y, x)
  c2s_cordic #(
    .STEPS (CORDIC_STEPS),
    .AFB   (ANGLE_FRAC_BITS)
  ) u_cordic_azi (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (sq_rho_vld),
    .in_b      (DP_W'($signed(side_q.y))),
    .in_a      (DP_W'($signed(side_q.x))),
    .out_valid (cd_azi_vld),
    .out_angle (cd_azi)
  );

  // radius and axis flag wait for the CORDIC
  always_ff @(posedge clk) begin
    rad_r[0].radius <= sq_rad;
    rad_r[0].axis   <= side_q.axis;
    for (int k = 1; k < CORDIC_LAT; k++) begin
      rad_r[k] <= rad_r[k-1];
    end
  end

  // on the z axis both angles are forced to zero; polar angle floors at zero
  always_comb begin
    if (rad_r[CORDIC_LAT-1].axis || cd_pol[ACC_W-1]) begin
      polar_nxt = '0;
    end else begin
      polar_nxt = cd_pol[POLAR_W-1:0];
    end
    if (rad_r[CORDIC_LAT-1].axis) begin
      azim_nxt = '0;
    end else begin
      azim_nxt = cd_azi[AZIM_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= cd_pol_vld;
    end
  end

  always_ff @(posedge clk) begin
    radius_r <= rad_r[CORDIC_LAT-1].radius;
    polar_r  <= polar_nxt;
    azim_r   <= azim_nxt;
    axis_r   <= rad_r[CORDIC_LAT-1].axis;
  end

  assign out_valid       = out_valid_r;
  assign out_radius      = radius_r;
  assign out_polar_angle = polar_r;
  assign out_azimuth     = azim_r;
  assign out_axis_error  = axis_r;

  `C2S_ASSERT_HOLDS(a_sqrt_lockstep, sq_rad_vld == sq_rho_vld, "square root lanes out of step")
  `C2S_ASSERT_HOLDS(a_cordic_lockstep, cd_pol_vld == cd_azi_vld, "CORDIC lanes out of step")
  `C2S_ASSERT_NEXT(a_request_enters, accept, v1_r, "taken request missing from stage 1")
  `C2S_ASSERT_NEXT(a_result_follows, cd_pol_vld, out_valid, "CORDIC result not presented")
  `C2S_ASSERT_IMPLIES(a_axis_zero, out_valid && out_axis_error, out_polar_angle == '0 && out_azimuth == '0, "axis result with nonzero angle")

endmodule

// File: test/testbench.sv
// Self-checking testbench for the cartesian to spherical converter.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import c2s_pkg::*;

  localparam int CORDIC_STEPS    = 24;
  localparam int ANGLE_FRAC_BITS = 28;
  localparam int CLK_PERIOD      = 8;
  localparam int RESET_CYCLES    = 8;
  localparam int RANDOM_REQUESTS = 1050;
  localparam int MAX_GAP         = 4;
  localparam int REPORT_LIMIT    = 10;
  // Covers the pipeline depth, with a little margin on top.
  localparam int DRAIN_CYCLES    = CORDIC_STEPS + 41 + 16;
  // Slowest legal run is about 1100 requests, each after the longest gap,
  // plus the pipeline; the limit is several times that.
  localparam int CYCLE_LIMIT     = 60000;

  localparam longint PI_RAD_Q30 = 64'sd3373259426;

  // atan(2^-i) in Q2.30
  localparam longint ATAN_STEP_Q30 [32] = '{
    'h3243F6A8, 'h1DAC6705, 'h0FADBAFC, 'h07F56EA6, 'h03FEAB76, 'h01FFD55B,
    'h00FFFAAA, 'h007FFF55, 'h003FFFEA, 'h001FFFFD, 'h000FFFFF, 'h0007FFFF,
    'h0003FFFF, 'h0001FFFF, 'h0000FFFF, 'h00007FFF, 'h00003FFF, 'h00001FFF,
    'h00000FFF, 'h000007FF, 'h000003FF, 'h000001FF, 'h000000FF, 'h0000007F,
    'h0000003F, 'h0000001F, 'h0000000F, 'h00000008, 'h00000004, 'h00000002,
    'h00000001, 'h00000000
  };

  localparam logic signed [COORD_W-1:0] COORD_MIN = 32'sh8000_0000;
  localparam logic signed [COORD_W-1:0] COORD_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [COORD_W-1:0] ONE_Q16   = 32'sh0001_0000;

  typedef struct packed {
    logic [ROOT_W-1:0]        radius;
    logic [POLAR_W-1:0]       polar;
    logic signed [AZIM_W-1:0] azim;
    logic                     axis_err;
  } sph_result_t;

  // One line of stimulus; typed rows carry their answer, the rest use the predictor.
  typedef struct {
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic signed [COORD_W-1:0] z;
    bit                        typed;
    sph_result_t               answer;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic signed [COORD_W-1:0] in_x_coord = '0;
  logic signed [COORD_W-1:0] in_y_coord = '0;
  logic signed [COORD_W-1:0] in_z_coord = '0;
  logic                      out_valid;
  logic [ROOT_W-1:0]         out_radius;
  logic [POLAR_W-1:0]        out_polar_angle;
  logic signed [AZIM_W-1:0]  out_azimuth;
  logic                      out_axis_error;

  // Answer for the request now on the ports; moves with the data (nonblocking)
  // so the checker picks up the value that belongs to the accepted request.
  sph_result_t pending_result = '0;
  sph_result_t expected_spherical [$];
  stim_row_t   stim_table [$];

  int mismatch_count = 0;
  int cycle_count = 0;
  int gap_free_left = 0;
  bit gap_free = 1'b0;

  cartesian_to_spherical #(
    .CORDIC_STEPS   (CORDIC_STEPS),
    .ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)
  ) uut (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_x_coord     (in_x_coord),
    .in_y_coord     (in_y_coord),
    .in_z_coord     (in_z_coord),
    .out_valid      (out_valid),
    .out_radius     (out_radius),
    .out_polar_angle(out_polar_angle),
    .out_azimuth    (out_azimuth),
    .out_axis_error (out_axis_error)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  // Bit-pair integer square root, then round to nearest (remainder > root).
  function automatic longint unsigned round_sqrt(input longint unsigned n);
    longint unsigned rem;
    longint unsigned root;
    longint unsigned bitv;
    rem  = n;
    root = 0;
    bitv = 64'd1 << 62;
    while (bitv > rem) bitv >>= 2;
    while (bitv != 0) begin
      if (rem >= root + bitv) begin
        rem  -= root + bitv;
        root  = (root >> 1) + bitv;
      end else begin
        root >>= 1;
      end
      bitv >>= 2;
    end
    if (rem > root) root += 1;
    return root;
  endfunction

  // Vectoring CORDIC for atan2(b, a), Q2.30 accumulator, rounded to the
  // output format and clamped to +-pi.
  function automatic longint vector_angle(input longint b_in, input longint a_in);
    longint a;
    longint b;
    longint acc;
    longint da;
    longint db;
    longint q;
    longint lim;
    int     sh;
    a   = a_in;
    b   = b_in;
    acc = 0;
    // left half-plane: flip the vector and start from +-pi
    if (a < 0) begin
      acc = (b < 0) ? -PI_RAD_Q30 : PI_RAD_Q30;
      a   = -a;
      b   = -b;
    end
    for (int i = 0; i < CORDIC_STEPS && i < 32; i++) begin
      da = b >>> i;
      db = a >>> i;
      // zero second component counts as positive
      if (b >= 0) begin
        a   += da;
        b   -= db;
        acc += ATAN_STEP_Q30[i];
      end else begin
        a   -= da;
        b   += db;
        acc -= ATAN_STEP_Q30[i];
      end
    end
    sh  = 30 - ANGLE_FRAC_BITS;
    q   = (acc + (longint'(1) <<< (sh - 1))) >>> sh;
    lim = (PI_RAD_Q30 + (longint'(1) <<< (sh - 1))) >>> sh;
    if (q > lim) q = lim;
    if (q < -lim) q = -lim;
    return q;
  endfunction

  function automatic sph_result_t predict_spherical(input logic signed [COORD_W-1:0] x,
                                                    input logic signed [COORD_W-1:0] y,
                                                    input logic signed [COORD_W-1:0] z);
    sph_result_t     res;
    longint          xs;
    longint          ys;
    longint          zs;
    longint          rho;
    longint          polar;
    longint          azim;
    longint unsigned ax;
    longint unsigned ay;
    longint unsigned az;
    longint unsigned sxy;
    xs  = x;
    ys  = y;
    zs  = z;
    ax  = (xs < 0) ? -xs : xs;
    ay  = (ys < 0) ? -ys : ys;
    az  = (zs < 0) ? -zs : zs;
    sxy = ax * ax + ay * ay;
    res.radius   = ROOT_W'(round_sqrt(sxy + az * az));
    res.axis_err = (x == 0 && y == 0);
    polar = 0;
    azim  = 0;
    // on the z axis the angles stay zero, radius is still exact
    if (!res.axis_err) begin
      rho   = longint'(round_sqrt(sxy));
      polar = vector_angle(rho, zs);
      if (polar < 0) polar = 0;
      azim  = vector_angle(ys, xs);
    end
    res.polar = polar[POLAR_W-1:0];
    res.azim  = azim[AZIM_W-1:0];
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------

  task automatic add_predicted(input logic signed [COORD_W-1:0] x,
                               input logic signed [COORD_W-1:0] y,
                               input logic signed [COORD_W-1:0] z);
    stim_table.push_back('{x, y, z, 1'b0, '0});
  endtask

  // z-axis rows: angles read zero, radius is |z|, error flag set
  task automatic add_axis(input logic signed [COORD_W-1:0] z,
                          input logic [ROOT_W-1:0] radius);
    sph_result_t ans;
    ans = '{radius, '0, '0, 1'b1};
    stim_table.push_back('{'0, '0, z, 1'b1, ans});
  endtask

  // Mix of zeros, extremes, small values, spread magnitudes and full-width noise.
  function automatic logic signed [COORD_W-1:0] draw_coord();
    logic signed [COORD_W-1:0] v;
    int                        pick;
    pick = $urandom_range(0, 15);
    v = $urandom;
    case (pick)
      0: v = '0;
      1: begin
        case ($urandom_range(0, 3))
          0:       v = COORD_MIN;
          1:       v = COORD_MAX;
          2:       v = 32'sd1;
          default: v = -32'sd1;
        endcase
      end
      2, 3, 4: v = int'($urandom_range(0, 32'h3FFFF)) - 32'sh20000;
      5, 6, 7: v = v >>> $urandom_range(0, 31);
      default: ;
    endcase
    return v;
  endfunction

  // Present one request, after a random gap outside gap-free runs, and hold it until taken.
  task automatic drive_request(input stim_row_t row);
    int gap;
    if (gap_free_left == 0) begin
      gap_free_left = $urandom_range(20, 60);
      gap_free      = ($urandom_range(0, 2) == 0);
    end
    gap_free_left--;
    gap = gap_free ? 0 : $urandom_range(0, MAX_GAP);
    if (gap != 0) begin
      // junk on the data ports while start is low must be ignored
      start      <= 1'b0;
      in_x_coord <= $urandom;
      in_y_coord <= $urandom;
      in_z_coord <= $urandom;
      repeat (gap) @(posedge clk);
    end
    start          <= 1'b1;
    in_x_coord     <= row.x;
    in_y_coord     <= row.y;
    in_z_coord     <= row.z;
    pending_result <= row.typed ? row.answer : predict_spherical(row.x, row.y, row.z);
    do @(posedge clk); while (busy);
  endtask

  initial begin
    stim_row_t rnd_row;

    // directed rows: z axis and origin first (answers known), then quadrants,
    // half-plane boundaries and extreme magnitudes
    add_axis('0, 32'h0000_0000);
    add_axis(ONE_Q16, 32'h0001_0000);
    add_axis(-ONE_Q16, 32'h0001_0000);
    add_axis(32'sd1, 32'h0000_0001);
    add_axis(COORD_MAX, 32'h7FFF_FFFF);
    add_axis(COORD_MIN, 32'h8000_0000);
    add_predicted(ONE_Q16, '0, '0);
    add_predicted(-ONE_Q16, '0, '0);          // y zero counts positive: +pi
    add_predicted(-ONE_Q16, -32'sd1, '0);     // just below the negative x axis
    add_predicted('0, ONE_Q16, '0);
    add_predicted('0, -ONE_Q16, '0);
    add_predicted(32'sd1, 32'sd1, 32'sd1);
    add_predicted(-32'sd1, -32'sd1, -32'sd1);
    add_predicted(COORD_MIN, COORD_MIN, COORD_MIN);  // largest radius
    add_predicted(COORD_MAX, COORD_MAX, COORD_MAX);
    add_predicted(COORD_MIN, '0, '0);
    add_predicted('0, COORD_MIN, '0);
    add_predicted(COORD_MAX, COORD_MIN, COORD_MIN);
    add_predicted(32'sd1, '0, COORD_MIN);     // polar close to pi
    add_predicted(-32'sd1, '0, COORD_MAX);    // polar close to 0, azimuth pi
    add_predicted(ONE_Q16, ONE_Q16, ONE_Q16);
    add_predicted(-ONE_Q16, ONE_Q16, -ONE_Q16);
    add_predicted(COORD_MIN, -32'sd1, '0);    // azimuth close to -pi

    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    foreach (stim_table[i]) drive_request(stim_table[i]);

    for (int n = 0; n < RANDOM_REQUESTS; n++) begin
      rnd_row.x = draw_coord();
      rnd_row.y = draw_coord();
      rnd_row.z = draw_coord();
      // steer some requests onto the z axis and onto the x-z plane
      case ($urandom_range(0, 15))
        0:       begin rnd_row.x = '0; rnd_row.y = '0; end
        1:       rnd_row.y = '0;
        default: ;
      endcase
      rnd_row.typed  = 1'b0;
      rnd_row.answer = '0;
      drive_request(rnd_row);
    end
    start <= 1'b0;

    // let the pipeline drain, then watch for stray results a while longer
    while (expected_spherical.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Result checking: compare first, then queue the request taken at this edge.
  // Both use pre-edge values, so ordering within the step cannot matter.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : check_results
    sph_result_t got;
    sph_result_t want;
    if (rst_n && out_valid) begin
      got = '{out_radius, out_polar_angle, out_azimuth, out_axis_error};
      if (expected_spherical.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= REPORT_LIMIT)
          $display("%0t: result with no request pending: r=%h polar=%h azim=%0d err=%b",
                   $realtime, got.radius, got.polar, got.azim, got.axis_err);
      end else begin
        want = expected_spherical.pop_front();
        if (got.radius !== want.radius || got.polar !== want.polar ||
            got.azim !== want.azim || got.axis_err !== want.axis_err) begin
          mismatch_count++;
          if (mismatch_count <= REPORT_LIMIT)
            $display("%0t: r=%h/%h polar=%h/%h azim=%0d/%0d err=%b/%b (expected/actual)",
                     $realtime, want.radius, got.radius, want.polar, got.polar,
                     want.azim, got.azim, want.axis_err, got.axis_err);
        end
      end
    end
    if (rst_n && start && !busy) expected_spherical.push_back(pending_result);
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

endmodule
